[hw/rtl/lphs_pkg.sv]
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared codes and types for the linear probing hash set: request kinds,
// slot marks, reply status, payload field widths and control state encoding.
// ----------------------------------------------------------------------------
package lphs_pkg;

  // request kinds (the spare code behaves as find)
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  // slot marks
  localparam logic [1:0] MARK_EMPTY  = 2'd0;
  localparam logic [1:0] MARK_FILLED = 2'd1;
  localparam logic [1:0] MARK_TOMB   = 2'd2;

  // reply status
  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_NOCHANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  // field widths of the stream payload
  localparam int KEY_BITS   = 32;
  localparam int HOME_BITS  = 8;
  localparam int SLOT_BITS  = 8;
  localparam int COUNT_BITS = 9;

  // control states
  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_PROBE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

[hw/rtl/lphs_ram.sv]
// ----------------------------------------------------------------------------
// lphs_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/linear_probe_hash_set.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Hash set with open addressing, linear probing and tombstones. Requests are
// add, remove or find of one key at a precomputed home slot.
// ----------------------------------------------------------------------------
// A request first takes the transfer and issues the read of its home slot,
// then probes n slots (from 1 up to TABLE_SIZE), one slot per cycle from the
// slot memory's read port, and then places the reply once the output is
// free. Slot state (mark and key) lives in a single RAM of TABLE_SIZE words;
// an add or remove that changes the set writes back once, in the last probe
// cycle. After reset the block marks all slots empty and takes no request
// during that sweep. A new request is accepted while the previous reply
// still waits on the output.
module linear_probe_hash_set #(
  parameter int TABLE_SIZE = 256,
  parameter int KEY_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // key[31:0], home_index[39:32]
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // found[0], slot[8:1], status[10:9],
                                // element_count[19:11], zero fill[23:20]
);

  import lphs_pkg::*;

  localparam int IW  = $clog2(TABLE_SIZE);
  localparam int CW  = $clog2(TABLE_SIZE + 1);
  localparam int KSW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
  localparam int MW  = 2 + KSW;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

  // next slot with wrap
  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
    return (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  // home index modulo table size, restoring reduction by a constant
  function automatic logic [IW-1:0] home_slot(input logic [HOME_BITS-1:0] h);
    logic [31:0] r;
    r = {24'd0, h};
    for (int k = HOME_BITS - 1; k >= 0; k--) begin
      if (r >= (32'(TABLE_SIZE) << k)) begin
        r = r - (32'(TABLE_SIZE) << k);
      end
    end
    return r[IW-1:0];
  endfunction

  state_t          state, state_next;
  logic [IW-1:0]   clr_idx;
  logic [IW-1:0]   cur;
  logic [IW-1:0]   step;
  logic            tomb_seen;
  logic [IW-1:0]   tomb;
  logic [1:0]      req_q;
  logic [KSW-1:0]  key_q;
  logic [CW-1:0]   filled_total, filled_total_next;
  logic            res_found, res_found_next;
  logic [IW-1:0]   res_slot, res_slot_next;
  logic [1:0]      res_status, res_status_next;

  // memory ports
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [MW-1:0]   ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [MW-1:0]   ram_rdata;

  // probe evaluation
  logic [1:0]      rd_mark;
  logic [KSW-1:0]  rd_key;
  logic            is_hit, is_empty, is_tomb, is_last, probe_done;
  logic            cand_ok;
  logic [IW-1:0]   cand;
  logic            in_xfer, out_free;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  lphs_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // slot under test this cycle
  assign rd_mark    = ram_rdata[MW-1 -: 2];
  assign rd_key     = ram_rdata[KSW-1:0];
  assign is_hit     = (rd_mark == MARK_FILLED) && (rd_key == key_q);
  assign is_tomb    = (rd_mark == MARK_TOMB);
  assign is_empty   = !is_hit && !is_tomb && (rd_mark != MARK_FILLED);
  assign is_last    = (step == LAST_IDX);
  assign probe_done = (state == ST_PROBE) && (is_hit || is_empty || is_last);
  assign cand_ok    = tomb_seen || is_tomb || is_empty;
  assign cand       = tomb_seen ? tomb : cur;

  // read address: home slot on a transfer, next slot while probing
  always_comb begin
    ram_raddr = cur;
    if (state == ST_IDLE) begin
      ram_raddr = home_slot(s_tdata[KEY_BITS +: HOME_BITS]);
    end else if (state == ST_PROBE) begin
      ram_raddr = idx_inc(cur);
    end
  end

  // clear sweep writes, and write back and reply decision at the end of the probe
  always_comb begin
    ram_we            = 1'b0;
    ram_waddr         = cand;
    ram_wdata         = {MARK_FILLED, key_q};
    filled_total_next = filled_total;
    res_found_next    = is_hit;
    res_slot_next     = '0;
    res_status_next   = STATUS_NOTFOUND;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = {MARK_EMPTY, {KSW{1'b0}}};
    end else if (probe_done) begin
      unique case (req_q)
        REQ_ADD: begin
          if (is_hit) begin
            res_slot_next   = cur;
            res_status_next = STATUS_NOCHANGE;
          end else if (cand_ok) begin
            ram_we            = 1'b1;
            filled_total_next = filled_total + 1'b1;
            res_slot_next     = cand;
            res_status_next   = STATUS_DONE;
          end else begin
            res_status_next = STATUS_FULL;
          end
        end
        REQ_REMOVE: begin
          if (is_hit) begin
            ram_we    = 1'b1;
            ram_waddr = cur;
            ram_wdata = {MARK_TOMB, key_q};
            if (filled_total != '0) begin
              filled_total_next = filled_total - 1'b1;
            end
            res_slot_next   = cur;
            res_status_next = STATUS_DONE;
          end else begin
            res_status_next = STATUS_NOCHANGE;
          end
        end
        default: begin
          if (is_hit) begin
            res_slot_next   = cur;
            res_status_next = STATUS_DONE;
          end
        end
      endcase
    end
  end

  // control state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:   if (in_xfer) state_next = ST_PROBE;
      ST_PROBE:  if (probe_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      filled_total <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      filled_total <= filled_total_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // probe walk and request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_q     <= s_tuser;
      key_q     <= s_tdata[KSW-1:0];
      cur       <= home_slot(s_tdata[KEY_BITS +: HOME_BITS]);
      step      <= '0;
      tomb_seen <= 1'b0;
      tomb      <= '0;
    end else if (state == ST_PROBE && !probe_done) begin
      cur  <= idx_inc(cur);
      step <= step + 1'b1;
      if (is_tomb && !tomb_seen) begin
        tomb_seen <= 1'b1;
        tomb      <= cur;
      end
    end
  end

  // reply capture and output transfer register
  always_ff @(posedge clk) begin
    logic [IW+SLOT_BITS-1:0]   slot_ext;
    logic [CW+COUNT_BITS-1:0]  count_ext;
    slot_ext  = {{SLOT_BITS{1'b0}}, res_slot};
    count_ext = {{COUNT_BITS{1'b0}}, filled_total};
    if (probe_done) begin
      res_found  <= res_found_next;
      res_slot   <= res_slot_next;
      res_status <= res_status_next;
    end
    if (state == ST_FINISH && out_free) begin
      m_tdata <= {4'd0, count_ext[COUNT_BITS-1:0], res_status,
                  slot_ext[SLOT_BITS-1:0], res_found};
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    filled_total <= CW'(TABLE_SIZE))
    else $error("element count above table size");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) && is_last |-> probe_done)
    else $error("probe walked past the whole table");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR) || probe_done)
    else $error("slot write outside clear sweep or probe end");

  a_no_reply_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !m_tvalid)
    else $error("reply offered during clear sweep");

  a_transfer_starts_probe: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_PROBE))
    else $error("accepted request did not start a probe");

endmodule

[tb/linear_probe_hash_set_tb.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_set_tb
// Self-checking bench for the linear probing hash set. A local mirror of the
// slot table predicts every reply; requests cover add, remove, find and the
// spare request code, tombstone reuse, wrap-around probes, random traffic on
// clustered keys, and a completely filled table. Both stream sides stall in
// random bursts except in a stretch of random traffic and the full-table phase.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_tb;
  import lphs_pkg::*;

  localparam int SLOTS       = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 300;

  // reply fields, found in the lowest bit as on the stream
  typedef struct packed {
    logic [COUNT_BITS-1:0] element_count;
    logic [1:0]            status;
    logic [SLOT_BITS-1:0]  slot;
    logic                  found;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // key[31:0], home_index[39:32]
  logic [1:0]  s_tuser = REQ_FIND;  // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;  // found[0], slot[8:1], status[10:9], element_count[19:11]

  // mirror of the slot table
  logic [KEY_BITS-1:0] mirror_key [SLOTS];
  logic [1:0]          mirror_mark [SLOTS];
  int unsigned         mirror_count = 0;

  reply_t pending_replies [$];
  int     errors = 0;
  int     idle_pct = 0;
  int     stall_left = 0;
  int     cycle_count = 0;

  linear_probe_hash_set DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // upstream hash: xor of the key bytes
  function automatic logic [7:0] home_of(input logic [31:0] key);
    return key[7:0] ^ key[15:8] ^ key[23:16] ^ key[31:24];
  endfunction

  // key with given upper bits whose hash lands on the given slot
  function automatic logic [31:0] key_at(input logic [7:0] home, input logic [23:0] tag);
    return {tag, home ^ tag[7:0] ^ tag[15:8] ^ tag[23:16]};
  endfunction

  function automatic bit key_stored(input logic [31:0] key);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (mirror_mark[i] == MARK_FILLED && mirror_key[i] == key) hit = 1'b1;
    return hit;
  endfunction

  // key not in the set, optionally pinned to a home slot
  function automatic logic [31:0] fresh_key(input bit pinned, input logic [7:0] home);
    logic [31:0] key;
    do key = pinned ? key_at(home, 24'($urandom)) : $urandom;
    while (key_stored(key));
    return key;
  endfunction

  // probe the mirror and apply one request, returning the reply
  function automatic reply_t apply_request(input logic [1:0] req, input logic [31:0] key,
                                           input logic [7:0] home);
    reply_t r;
    int i;
    int pos;
    int hit_slot;
    int first_tomb;
    int cand;
    bit stop;
    hit_slot   = -1;
    first_tomb = -1;
    cand       = -1;
    stop       = 1'b0;
    for (i = 0; i < SLOTS && !stop; i++) begin
      pos = (int'(home) + i) % SLOTS;
      if (mirror_mark[pos] == MARK_FILLED) begin
        if (mirror_key[pos] == key) begin
          hit_slot = pos;
          stop = 1'b1;
        end
      end else if (mirror_mark[pos] == MARK_TOMB) begin
        if (first_tomb < 0) first_tomb = pos;
      end else begin
        cand = (first_tomb >= 0) ? first_tomb : pos;
        stop = 1'b1;
      end
    end
    // whole table walked without an empty slot
    if (!stop && first_tomb >= 0) cand = first_tomb;

    r.found = (hit_slot >= 0);
    r.slot  = '0;
    case (req)
      REQ_ADD: begin
        if (hit_slot >= 0) begin
          r.slot = 8'(hit_slot);
          r.status = STATUS_NOCHANGE;
        end else if (cand >= 0) begin
          mirror_key[cand]  = key;
          mirror_mark[cand] = MARK_FILLED;
          mirror_count++;
          r.slot = 8'(cand);
          r.status = STATUS_DONE;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      REQ_REMOVE: begin
        if (hit_slot >= 0) begin
          mirror_mark[hit_slot] = MARK_TOMB;
          if (mirror_count > 0) mirror_count--;
          r.slot = 8'(hit_slot);
          r.status = STATUS_DONE;
        end else begin
          r.status = STATUS_NOCHANGE;
        end
      end
      default: begin
        // find, and the spare code that acts as find
        if (hit_slot >= 0) begin
          r.slot = 8'(hit_slot);
          r.status = STATUS_DONE;
        end else begin
          r.status = STATUS_NOTFOUND;
        end
      end
    endcase
    r.element_count = mirror_count[COUNT_BITS-1:0];
    return r;
  endfunction

  // one request transfer, with an optional idle burst ahead of it
  task automatic send_request(input logic [1:0] req, input logic [31:0] key);
    int gap;
    logic [7:0] home;
    home = home_of(key);
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {home, key};
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    pending_replies.push_back(apply_request(req, key, home));
  endtask

  // reply side: check each transfer, then decide on a stall
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (m_tvalid && m_tready) begin
      got = reply_t'(m_tdata[19:0]);
      if (pending_replies.size() == 0) begin
        $error("reply with none outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, got.found);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, got.slot);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          errors++;
        end
        if (got.element_count !== want.element_count) begin
          $error("element_count: expected %0d, actual %0d", want.element_count,
                 got.element_count);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 15) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("linear_probe_hash_set verification failed");
      $finish;
    end
  end

  // basic operations, collisions, tombstones and wrap-around
  task automatic test_basic_ops();
    logic [31:0] k_a;
    logic [31:0] k_b;
    logic [31:0] k_c;
    idle_pct = 20;
    k_a = key_at(8'd0, 24'h123456);
    k_b = key_at(8'd255, 24'hABCDEF);
    k_c = key_at(8'd255, 24'h00FF00);
    send_request(REQ_FIND, 32'h0000_0000);    // empty table
    send_request(REQ_ADD, 32'h0000_0000);
    send_request(REQ_ADD, 32'h0000_0000);     // duplicate
    send_request(REQ_ADD, 32'hFFFF_FFFF);     // same home, next slot
    send_request(REQ_FIND, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'h0000_0000);  // absent
    send_request(REQ_FIND, 32'hFFFF_FFFF);    // probe past a tombstone
    send_request(REQ_SPARE, 32'hFFFF_FFFF);   // spare code acts as find
    send_request(REQ_REMOVE, 32'hFFFF_FFFF);
    send_request(REQ_ADD, k_a);               // takes the first of two tombstones
    send_request(REQ_ADD, k_b);               // top slot
    send_request(REQ_ADD, k_c);               // wraps to the tombstone at slot 1
    send_request(REQ_SPARE, k_c);
    send_request(REQ_FIND, key_at(8'd255, 24'h5A5A5A));  // wraps until empty
    send_request(REQ_REMOVE, k_b);
    send_request(REQ_ADD, k_b);
    send_request(REQ_REMOVE, key_at(8'd254, 24'hC3C3C3));
    send_request(REQ_FIND, k_a);
  endtask

  // random traffic on a key pool, half of it clustered around the wrap point
  task automatic test_random_traffic();
    logic [31:0] pool [64];
    logic [31:0] key;
    logic [1:0]  req;
    int pick;
    for (int i = 0; i < 64; i++)
      pool[i] = (i < 32) ? $urandom : key_at(8'(252 + i % 8), 24'($urandom));
    for (int n = 0; n < 200; n++) begin
      idle_pct = ((n / 60) % 3 == 2) ? 0 : 25;
      pick = $urandom_range(0, 99);
      if (pick < 40) req = REQ_ADD;
      else if (pick < 65) req = REQ_REMOVE;
      else if (pick < 90) req = REQ_FIND;
      else req = REQ_SPARE;
      key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 63)] : $urandom;
      send_request(req, key);
    end
  endtask

  // fill every slot, then work on a table with no empty slot
  task automatic test_full_table();
    logic [31:0] k_gone;
    idle_pct = 0;
    while (mirror_count < SLOTS) send_request(REQ_ADD, fresh_key(1'b0, 8'd0));
    send_request(REQ_ADD, fresh_key(1'b0, 8'd0));     // no room
    send_request(REQ_FIND, fresh_key(1'b0, 8'd0));    // walks the whole table
    send_request(REQ_SPARE, fresh_key(1'b0, 8'd0));
    send_request(REQ_ADD, mirror_key[77]);            // duplicate
    send_request(REQ_REMOVE, mirror_key[37]);
    send_request(REQ_ADD, fresh_key(1'b0, 8'd0));     // reuses the lone tombstone
    k_gone = mirror_key[200];
    send_request(REQ_REMOVE, k_gone);
    send_request(REQ_REMOVE, mirror_key[10]);
    send_request(REQ_ADD, fresh_key(1'b1, 8'd5));     // first tombstone from slot 5
    send_request(REQ_ADD, fresh_key(1'b1, 8'd5));     // the later one
    send_request(REQ_ADD, fresh_key(1'b1, 8'd5));     // full again
    send_request(REQ_FIND, k_gone);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mirror_key[i]  = '0;
      mirror_mark[i] = MARK_EMPTY;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_random_traffic();
    test_full_table();

    s_tvalid <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("linear_probe_hash_set verification clean");
    end else begin
      $display("linear_probe_hash_set verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lphs_pkg.sv
hw/rtl/lphs_ram.sv
hw/rtl/linear_probe_hash_set.sv
tb/linear_probe_hash_set_tb.sv
